// ===== rtl/core/bpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the bitmap page allocator
// Request and response field widths, opcodes, status codes, sequencer states.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned PAGE_W         = 20;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned PAGE_COUNT_DEF = 1048576;
  localparam int unsigned WORD_BITS_DEF  = 32;

  localparam logic [PAGE_W-1:0] FIRST_PAGE_RESET = 20'h04000;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_NO_PAGE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOCATE = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_RESERVE  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MOD_RD,
    ST_MOD_WR,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/bpa_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_req_if: request channel of the bitmap page allocator
// Valid/ready handshake carrying opcode and page number.
// ----------------------------------------------------------------------------
interface bpa_req_if
  import bpa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output opcode, output page_number, input ready);
  modport sink   (input valid, input opcode, input page_number, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bpa_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_rsp_if: response channel of the bitmap page allocator
// Valid/ready handshake carrying granted page and status.
// ----------------------------------------------------------------------------
interface bpa_rsp_if
  import bpa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] granted_page;
  logic              status;

  modport source (output valid, output granted_page, output status, input ready);
  modport sink   (input valid, input granted_page, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bpa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/bpa_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_divider: page-number splitter
// Word index and bit offset by shift and mask, registered.
// WORD_BITS must be a power of two, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module bpa_divider
  import bpa_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  localparam int unsigned BIT_W    = $clog2(WORD_BITS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PAGE_W-1:0] dividend_i,
  output logic                   done_o,
  output logic      [PAGE_W-1:0] quotient_o,
  output logic      [BIT_W-1:0]  remainder_o
);

  logic              done_q;
  logic [PAGE_W-1:0] quo_q;
  logic [BIT_W-1:0]  rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i >> BIT_W;
      rem_q <= dividend_i[BIT_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

// ===== rtl/core/bitmap_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator: first-fit physical page allocator
// Requests arrive on req_i (opcode, page_number) and each gives one response
// on rsp_o (granted_page, status). Allocate scans the occupancy map first-fit
// from first_dynamic_page; release clears a page bit; reserve sets it.
// first_dynamic_page is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, which the block itself does not enforce. One
// request is in flight at a time. Allocate splits first_dynamic_page, and
// release and reserve their page number, into word index and bit offset in
// one register stage. Release and reserve then take a read and a write of
// the map word. Allocate reads one map word per cycle from the start word
// to the last word and stops at the first word with a free page. Allocates
// starting past the map, releases and reserves past it, and the unused
// opcode skip the split and the map. The block is ready for the next
// request in the cycle after the response is loaded. After reset the map is
// cleared one word per cycle, MAP_WORDS words (32768 by default), with
// req_i.ready low; config writes still land. The response is held in an
// output register: a stalled receiver holds it, the block still takes the
// next request, and finishes that one only once the held response is taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [PAGE_W-1:0] cfg_wdata_i,
  bpa_req_if.sink                req_i,
  bpa_rsp_if.source              rsp_o
);

  localparam int unsigned MAP_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAP_WORDS + 1);
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned BASE_W    = PAGE_W + 1;

  localparam logic [BASE_W-1:0] PAGE_LIMIT = BASE_W'(PAGE_COUNT);
  localparam logic [BASE_W-1:0] WORD_STEP  = BASE_W'(WORD_BITS);
  localparam logic [CNT_W-1:0]  WORD_END   = CNT_W'(MAP_WORDS);
  localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(MAP_WORDS - 1);

  state_e state_q, state_d;

  logic [PAGE_W-1:0]    cfg_q;
  logic [OP_W-1:0]      op_q;
  logic [ADDR_W-1:0]    clr_q;
  logic [CNT_W-1:0]     issue_q;
  logic [BASE_W-1:0]    issue_base_q;
  logic                 first_pend_q;
  logic                 chk_vld_q;
  logic                 chk_first_q;
  logic [ADDR_W-1:0]    chk_word_q;
  logic [BASE_W-1:0]    chk_base_q;
  logic [PAGE_W-1:0]    res_page_q;
  logic                 res_status_q;
  logic                 out_valid_q;
  logic [PAGE_W-1:0]    out_page_q;
  logic                 out_status_q;

  logic                 req_fire;
  logic                 need_div;
  logic                 cfg_out_range;
  logic                 pg_out_range;
  logic                 div_start;
  logic [PAGE_W-1:0]    div_dividend;
  logic                 div_done;
  logic [PAGE_W-1:0]    div_quot;
  logic [BIT_W-1:0]     div_rem;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 issue;
  logic                 scan_end;
  logic [WORD_BITS-1:0] free_w;
  logic [WORD_BITS-1:0] mod_mask;
  logic [BIT_W-1:0]     free_idx;
  logic                 found;
  logic [BASE_W-1:0]    cand;
  logic                 cand_ok;
  logic                 out_free;

  assign req_fire      = req_i.valid && req_i.ready;
  assign cfg_out_range = {1'b0, cfg_q} >= PAGE_LIMIT;
  assign pg_out_range  = {1'b0, req_i.page_number} >= PAGE_LIMIT;
  assign out_free      = !out_valid_q || rsp_o.ready;
  assign issue         = (issue_q != WORD_END);
  assign scan_end      = !issue;

  always_comb begin
    case (op_e'(req_i.opcode))
      OP_ALLOCATE: need_div = !cfg_out_range;
      OP_RELEASE,
      OP_RESERVE:  need_div = !pg_out_range;
      default:     need_div = 1'b0;
    endcase
  end

  assign div_start    = req_fire && need_div;
  assign div_dividend = (op_e'(req_i.opcode) == OP_ALLOCATE) ? cfg_q : req_i.page_number;

  bpa_divider #(
    .WORD_BITS (WORD_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    free_w = ~ram_rdata;
    if (chk_first_q) begin
      free_w = free_w & ({WORD_BITS{1'b1}} << div_rem);
    end
    free_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_w[i]) begin
        free_idx = BIT_W'(i);
      end
    end
  end

  assign found    = chk_vld_q && (|free_w);
  assign cand     = chk_base_q + BASE_W'(free_idx);
  assign cand_ok  = cand < PAGE_LIMIT;
  assign mod_mask = WORD_BITS'(1) << div_rem;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          state_d = need_div ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = (op_e'(op_q) == OP_ALLOCATE) ? ST_SCAN : ST_MOD_RD;
        end
      end
      ST_MOD_RD: state_d = ST_MOD_WR;
      ST_MOD_WR: state_d = ST_FINISH;
      ST_SCAN: begin
        if (found || scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    req_i.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = chk_word_q;
    ram_wdata   = ram_rdata | mod_mask;
    ram_re      = 1'b0;
    ram_raddr   = issue_q[ADDR_W-1:0];
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: req_i.ready = 1'b1;
      ST_MOD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = div_quot[ADDR_W-1:0];
      end
      ST_MOD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = div_quot[ADDR_W-1:0];
        ram_wdata = (op_e'(op_q) == OP_RELEASE) ? (ram_rdata & ~mod_mask)
                                                : (ram_rdata | mod_mask);
      end
      ST_SCAN: begin
        ram_re    = issue;
        ram_we    = found && cand_ok;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << free_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cfg_q       <= FIRST_PAGE_RESET;
      clr_q       <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (state_q == ST_SCAN) begin
        chk_vld_q <= issue && !found;
      end else begin
        chk_vld_q <= 1'b0;
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q         <= req_i.opcode;
      res_page_q   <= '0;
      res_status_q <= (op_e'(req_i.opcode) == OP_ALLOCATE) ? STATUS_NO_PAGE : STATUS_DONE;
    end
    if (state_q == ST_DIV && div_done) begin
      issue_q      <= CNT_W'(div_quot);
      issue_base_q <= {1'b0, cfg_q} - BASE_W'(div_rem);
      first_pend_q <= 1'b1;
    end
    if (state_q == ST_SCAN) begin
      if (issue) begin
        issue_q      <= issue_q + CNT_W'(1);
        issue_base_q <= issue_base_q + WORD_STEP;
        chk_word_q   <= issue_q[ADDR_W-1:0];
        chk_base_q   <= issue_base_q;
        chk_first_q  <= first_pend_q;
        first_pend_q <= 1'b0;
      end
      if (found && cand_ok) begin
        res_page_q   <= cand[PAGE_W-1:0];
        res_status_q <= STATUS_DONE;
      end
    end
    if (state_q == ST_FINISH && out_free) begin
      out_page_q   <= res_page_q;
      out_status_q <= res_status_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted_page = out_page_q;
  assign rsp_o.status       = out_status_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_bitmap_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator: self-checking testbench for the page allocator
// Drives allocate, release and reserve requests with random gaps on both
// channels and keeps its own occupancy set, which gives the granted page and
// status of every request in order. Each response is checked against that
// prediction. Covers first-page settings from zero to the last page, failed
// allocation, word-boundary scans, a long response hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned LIMIT_CYCLES = 1500000;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned GAP_PERCENT  = 37;

  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT_DEF - 1);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              status;
  } page_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [PAGE_W-1:0] cfg_wdata_i;

  bpa_req_if req_bus ();
  bpa_rsp_if rsp_bus ();

  bitmap_page_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  bit                page_used [int unsigned];
  int unsigned       live_pages[$];
  logic [PAGE_W-1:0] first_page_cfg = FIRST_PAGE_RESET;
  page_result_t      result_q[$];
  int unsigned       mismatch_count   = 0;
  bit                src_gaps_on      = 1'b1;
  bit                sink_gaps_on     = 1'b1;
  int unsigned       sink_hold_cycles = 0;

  always #CLK_HALF clk_i = ~clk_i;

  function automatic page_result_t apply_page_request(input logic [OP_W-1:0]   op,
                                                      input logic [PAGE_W-1:0] pg);
    page_result_t r;
    int unsigned  p;
    r.page   = '0;
    r.status = STATUS_DONE;
    case (op)
      OP_ALLOCATE: begin
        p = 32'(first_page_cfg);
        while (p < PAGE_COUNT_DEF && page_used.exists(p)) p++;
        if (p >= PAGE_COUNT_DEF) begin
          r.status = STATUS_NO_PAGE;
        end else begin
          page_used[p] = 1'b1;
          r.page = p[PAGE_W-1:0];
          live_pages.push_back(p);
        end
      end
      OP_RELEASE: begin
        if (pg < PAGE_COUNT_DEF && page_used.exists(32'(pg))) page_used.delete(32'(pg));
      end
      OP_RESERVE: begin
        if (pg < PAGE_COUNT_DEF) page_used[32'(pg)] = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg);
    if (src_gaps_on) begin
      while ($urandom_range(99) < GAP_PERCENT) begin
        req_bus.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    req_bus.valid       <= 1'b1;
    req_bus.opcode      <= op;
    req_bus.page_number <= pg;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    result_q.push_back(apply_page_request(op, pg));
    @(negedge clk_i);
  endtask

  task automatic settle_requests();
    req_bus.valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_first_page(input logic [PAGE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    first_page_cfg = value;
    @(negedge clk_i);
  endtask

  task automatic send_random_request();
    int unsigned       roll;
    int unsigned       idx;
    int unsigned       near_page;
    logic [PAGE_W-1:0] pg;
    roll = $urandom_range(99);
    pg   = PAGE_W'($urandom());
    if (roll < 45) begin
      send_request(OP_ALLOCATE, pg);
    end else if (roll < 70) begin
      if (live_pages.size() != 0 && $urandom_range(99) < 80) begin
        idx = $urandom_range(live_pages.size() - 1);
        pg  = PAGE_W'(live_pages[idx]);
        live_pages.delete(idx);
      end
      send_request(OP_RELEASE, pg);
    end else if (roll < 90) begin
      near_page = 32'(first_page_cfg) + $urandom_range(40);
      if (near_page < PAGE_COUNT_DEF && $urandom_range(99) < 70) begin
        pg = PAGE_W'(near_page);
        live_pages.push_back(near_page);
      end
      send_request(OP_RESERVE, pg);
    end else begin
      send_request(OP_UNUSED, pg);
    end
  endtask

  task automatic run_random_phase(input logic [PAGE_W-1:0] first_page,
                                  input int unsigned count);
    settle_requests();
    write_first_page(first_page);
    repeat (count) send_random_request();
  endtask

  task automatic test_directed();
    send_request(OP_ALLOCATE, LAST_PAGE);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_RESERVE, 20'h04002);
    send_request(OP_ALLOCATE, 20'h12345);
    send_request(OP_RELEASE, 20'h04000);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_RELEASE, 20'h05000);
    send_request(OP_RESERVE, 20'h04001);
    send_request(OP_UNUSED, LAST_PAGE);
    send_request(OP_RESERVE, LAST_PAGE);
    send_request(OP_RELEASE, LAST_PAGE);
    send_request(OP_RESERVE, '0);
    send_request(OP_RELEASE, '0);
    settle_requests();
    write_first_page(LAST_PAGE);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_RELEASE, LAST_PAGE);
    send_request(OP_ALLOCATE, '0);
    settle_requests();
    write_first_page('0);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_RESERVE, 20'h00001);
    send_request(OP_ALLOCATE, '0);
    settle_requests();
    write_first_page(20'h0001F);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_UNUSED, '0);
    send_request(OP_RELEASE, 20'hAAAAA);
    send_request(OP_RESERVE, 20'h55555);
  endtask

  task automatic test_random_configs();
    run_random_phase(FIRST_PAGE_RESET, 100);
    run_random_phase('0, 100);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    run_random_phase(LAST_PAGE - PAGE_W'($urandom_range(40, 8)), 100);
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    run_random_phase(PAGE_W'($urandom()), 100);
    run_random_phase(LAST_PAGE - PAGE_W'($urandom_range(3)), 100);
    run_random_phase(FIRST_PAGE_RESET + PAGE_W'($urandom_range(31)), 100);
  endtask

  task automatic test_backpressure();
    settle_requests();
    sink_hold_cycles = HOLD_CYCLES;
    repeat (16) send_random_request();
  endtask

  task automatic test_drain_pause();
    repeat (10) send_random_request();
    settle_requests();
    repeat (10) send_random_request();
  endtask

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles != 0) begin
        rsp_bus.ready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        rsp_bus.ready <= !(sink_gaps_on && $urandom_range(99) < GAP_PERCENT);
      end
    end
  end

  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (result_q.size() == 0) begin
        report_mismatch("response with no request pending", 32'(rsp_bus.granted_page), 0);
      end else begin
        want = result_q.pop_front();
        if (rsp_bus.granted_page !== want.page)
          report_mismatch("granted_page", 32'(rsp_bus.granted_page), 32'(want.page));
        if (rsp_bus.status !== want.status)
          report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    req_bus.valid       = 1'b0;
    req_bus.opcode      = OP_ALLOCATE;
    req_bus.page_number = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_configs();
    test_backpressure();
    test_drain_pause();

    settle_requests();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (result_q.size() != 0)
      report_mismatch("requests left without response", 32'(result_q.size()), 0);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bpa_pkg.sv
rtl/core/bpa_req_if.sv
rtl/core/bpa_rsp_if.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_divider.sv
rtl/core/bitmap_page_allocator.sv
tb/sv/tb_bitmap_page_allocator.sv
